/* hw/rtl/simt_divergence_stack_control_macros.svh */
// ----------------------------------------------------------------------------
// SIMT divergence stack control assertion macros
// Shared concurrent assertion forms, clocked on clk_i with reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef SIMT_DIVERGENCE_STACK_CONTROL_MACROS_SVH
`define SIMT_DIVERGENCE_STACK_CONTROL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIMTDS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("simtds assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SIMTDS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("simtds assertion failed");

`endif

/* hw/rtl/simtds_pkg.sv */
// ----------------------------------------------------------------------------
// SIMT divergence stack control package
// Sizes, codes and shared types of the warp control unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package simtds_pkg;

  localparam int LANE_COUNT  = 32;
  localparam int STACK_DEPTH = 16;
  localparam int PC_BITS     = 16;

  localparam int SP_W  = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);

  localparam int ACTION_W   = 3;
  localparam int OFFSET_W   = 16;
  localparam int PRED_W     = 32;
  localparam int STATUS_W   = 3;
  localparam int OUT_PC_W   = 16;
  localparam int OUT_MASK_W = 32;
  localparam int LEVEL_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int START_PC_W = 16;

  localparam logic [ACTION_W-1:0] ACT_OTHER   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_BRANCH  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_SSY     = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_SYNC    = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_BARRIER = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TAKEN      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BARRIER    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SYNC_EMPTY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DIVERGENT  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_START_PC    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAUNCH_MASK = 1'b1;

  localparam logic [LANE_COUNT-1:0] ALL_LANES  = {LANE_COUNT{1'b1}};
  localparam logic [SP_W-1:0]       FULL_SP    = SP_W'(STACK_DEPTH);
  localparam logic [LEVEL_W-1:0]    FULL_LEVEL = LEVEL_W'(STACK_DEPTH);

  typedef struct packed {
    logic [LANE_COUNT-1:0] mask;
    logic [PC_BITS-1:0]    target;
    logic [PC_BITS-1:0]    rejoin;
  } simtds_entry_t;

  typedef struct packed {
    logic cfg_write;
    logic latch_in;
    logic read_top;
    logic execute;
  } simtds_cmd_t;

endpackage

/* hw/rtl/simtds_if.sv */
// ----------------------------------------------------------------------------
// SIMT divergence stack control channels
// Valid/ready channels for configuration, instructions and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface simtds_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [simtds_pkg::CFG_IDX_W-1:0]     index;
  logic [simtds_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface simtds_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [simtds_pkg::ACTION_W-1:0]      action;
  logic signed [simtds_pkg::OFFSET_W-1:0] branch_offset;
  logic [simtds_pkg::PRED_W-1:0]        lane_predicates;

  modport source (output valid, output action, output branch_offset,
                  output lane_predicates, input ready);
  modport sink (input valid, input action, input branch_offset,
                input lane_predicates, output ready);
endinterface

interface simtds_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [simtds_pkg::STATUS_W-1:0]      status;
  logic [simtds_pkg::OUT_PC_W-1:0]      next_pc;
  logic [simtds_pkg::OUT_MASK_W-1:0]    lane_mask;
  logic [simtds_pkg::LEVEL_W-1:0]       stack_level;

  modport source (output valid, output status, output next_pc, output lane_mask,
                  output stack_level, input ready);
  modport sink (input valid, input status, input next_pc, input lane_mask,
                input stack_level, output ready);
endinterface

/* hw/rtl/simtds_ctrl.sv */
// ----------------------------------------------------------------------------
// SIMT divergence stack controller
// Sequences accept, stack read, execute and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module simtds_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  output simtds_pkg::simtds_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q & ~out_ready_i;
    cmd_o         = '0;
    cmd_o.cfg_write = cfg_valid_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd_o.read_top = 1'b1;
        state_d        = S_EXEC;
      end
      S_EXEC: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.execute = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cfg_ready_o = 1'b1;

endmodule

/* hw/rtl/simtds_datapath.sv */
// ----------------------------------------------------------------------------
// SIMT divergence stack datapath
// Warp PC, lane mask, reconvergence PC, divergence stack and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module simtds_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  simtds_pkg::simtds_cmd_t               cmd_i,
  input  logic [simtds_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [simtds_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [simtds_pkg::ACTION_W-1:0]       action_i,
  input  logic signed [simtds_pkg::OFFSET_W-1:0] branch_offset_i,
  input  logic [simtds_pkg::PRED_W-1:0]         lane_predicates_i,
  output logic [simtds_pkg::STATUS_W-1:0]       status_o,
  output logic [simtds_pkg::OUT_PC_W-1:0]       next_pc_o,
  output logic [simtds_pkg::OUT_MASK_W-1:0]     lane_mask_o,
  output logic [simtds_pkg::LEVEL_W-1:0]        stack_level_o
);

  localparam int LC  = simtds_pkg::LANE_COUNT;
  localparam int PW  = simtds_pkg::PC_BITS;
  localparam int SPW = simtds_pkg::SP_W;
  localparam int IW  = simtds_pkg::IDX_W;

  logic [simtds_pkg::START_PC_W-1:0] start_pc_q;
  logic [simtds_pkg::CFG_DATA_W-1:0] launch_mask_q;

  logic [PW-1:0]  pc_q, pc_d;
  logic [LC-1:0]  act_q, act_d;
  logic [PW-1:0]  rej_q, rej_d;
  logic [SPW-1:0] sp_q, sp_d;

  logic [simtds_pkg::ACTION_W-1:0] action_q;
  logic [PW-1:0]                   off_q;
  logic [LC-1:0]                   pred_q;
  logic [31:0]                     off_wide;

  simtds_pkg::simtds_entry_t stack_mem [simtds_pkg::STACK_DEPTH];
  simtds_pkg::simtds_entry_t top_q;
  simtds_pkg::simtds_entry_t push_data;
  logic                      push;
  logic [SPW-1:0]            sp_m1;

  logic [simtds_pkg::START_PC_W-1:0] new_start;
  logic [simtds_pkg::CFG_DATA_W-1:0] new_mask;

  logic [LC-1:0]                   taken;
  logic [PW-1:0]                   seq_pc;
  logic [PW-1:0]                   dest_pc;
  logic [simtds_pkg::STATUS_W-1:0] st;

  logic [simtds_pkg::STATUS_W-1:0]   status_q;
  logic [simtds_pkg::OUT_PC_W-1:0]   next_pc_q;
  logic [simtds_pkg::OUT_MASK_W-1:0] lane_mask_q;
  logic [simtds_pkg::LEVEL_W-1:0]    level_q;

  assign off_wide = 32'(branch_offset_i);
  assign sp_m1    = sp_q - SPW'(1);

  always_comb begin
    new_start = start_pc_q;
    new_mask  = launch_mask_q;
    case (cfg_index_i)
      simtds_pkg::CFG_START_PC:    new_start = cfg_data_i[simtds_pkg::START_PC_W-1:0];
      simtds_pkg::CFG_LAUNCH_MASK: new_mask  = cfg_data_i;
      default: begin
      end
    endcase
  end

  always_comb begin
    taken     = act_q & pred_q;
    seq_pc    = pc_q + PW'(1);
    dest_pc   = pc_q + off_q;
    pc_d      = pc_q;
    act_d     = act_q;
    rej_d     = rej_q;
    sp_d      = sp_q;
    st        = simtds_pkg::ST_DONE;
    push      = 1'b0;
    push_data = '{mask: act_q & ~taken, target: seq_pc, rejoin: rej_q};
    case (action_q)
      simtds_pkg::ACT_BRANCH: begin
        if (taken == '0) begin
          pc_d = seq_pc;
        end else if (taken == act_q) begin
          pc_d = dest_pc;
          st   = simtds_pkg::ST_TAKEN;
        end else if (sp_q == simtds_pkg::FULL_SP) begin
          st = simtds_pkg::ST_OVERFLOW;
        end else begin
          push  = 1'b1;
          act_d = taken;
          pc_d  = dest_pc;
          sp_d  = sp_q + SPW'(1);
          st    = simtds_pkg::ST_TAKEN;
        end
      end
      simtds_pkg::ACT_SSY: begin
        if (sp_q == simtds_pkg::FULL_SP) begin
          st = simtds_pkg::ST_OVERFLOW;
        end else begin
          push      = 1'b1;
          push_data = '{mask: act_q, target: dest_pc, rejoin: rej_q};
          rej_d     = dest_pc;
          pc_d      = seq_pc;
          sp_d      = sp_q + SPW'(1);
        end
      end
      simtds_pkg::ACT_SYNC: begin
        if (sp_q == '0) begin
          st = simtds_pkg::ST_SYNC_EMPTY;
        end else begin
          sp_d  = sp_m1;
          act_d = top_q.mask;
          rej_d = top_q.rejoin;
          pc_d  = (top_q.target == pc_q) ? seq_pc : top_q.target;
        end
      end
      simtds_pkg::ACT_BARRIER: begin
        if (act_q != simtds_pkg::ALL_LANES) begin
          st = simtds_pkg::ST_DIVERGENT;
        end else begin
          st   = simtds_pkg::ST_BARRIER;
          pc_d = seq_pc;
        end
      end
      default: begin
        pc_d = seq_pc;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_pc_q    <= '0;
      launch_mask_q <= '1;
      pc_q          <= '0;
      act_q         <= simtds_pkg::ALL_LANES;
      rej_q         <= '0;
      sp_q          <= '0;
    end else if (cmd_i.cfg_write) begin
      start_pc_q    <= new_start;
      launch_mask_q <= new_mask;
      pc_q          <= PW'(new_start);
      act_q         <= new_mask[LC-1:0];
      rej_q         <= '0;
      sp_q          <= '0;
    end else if (cmd_i.execute) begin
      pc_q  <= pc_d;
      act_q <= act_d;
      rej_q <= rej_d;
      sp_q  <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      action_q <= action_i;
      off_q    <= off_wide[PW-1:0];
      pred_q   <= lane_predicates_i[LC-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read_top) begin
      top_q <= stack_mem[sp_m1[IW-1:0]];
    end
    if (cmd_i.execute && push) begin
      stack_mem[sp_q[IW-1:0]] <= push_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      status_q    <= st;
      next_pc_q   <= simtds_pkg::OUT_PC_W'(pc_d);
      lane_mask_q <= simtds_pkg::OUT_MASK_W'(act_d);
      level_q     <= simtds_pkg::LEVEL_W'(sp_d);
    end
  end

  assign status_o      = status_q;
  assign next_pc_o     = next_pc_q;
  assign lane_mask_o   = lane_mask_q;
  assign stack_level_o = level_q;

endmodule

/* hw/rtl/simt_divergence_stack_control.sv */
// ----------------------------------------------------------------------------
// SIMT divergence stack control top level
// Flow: an accepted instruction item is latched, the stack top is read into a
// register, then the execute step writes the result register; no new item is
// taken before that execute step. Results wait in an output register.
// Reset: start PC 0, all lanes active, empty stack; stack memory is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module simt_divergence_stack_control (
  input  logic         clk_i,
  input  logic         rst_ni,
  simtds_cfg_if.sink   cfg_i,
  simtds_in_if.sink    in_i,
  simtds_out_if.source out_o
);

  simtds_pkg::simtds_cmd_t cmd;

  simtds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cfg_valid_i (cfg_i.valid),
    .cfg_ready_o (cfg_i.ready),
    .cmd_o       (cmd)
  );

  simtds_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_index_i       (cfg_i.index),
    .cfg_data_i        (cfg_i.data),
    .action_i          (in_i.action),
    .branch_offset_i   (in_i.branch_offset),
    .lane_predicates_i (in_i.lane_predicates),
    .status_o          (out_o.status),
    .next_pc_o         (out_o.next_pc),
    .lane_mask_o       (out_o.lane_mask),
    .stack_level_o     (out_o.stack_level)
  );

endmodule

/* hw/rtl/simtds_checker.sv */
// ----------------------------------------------------------------------------
// SIMT divergence stack control checker
// Port-level properties of the warp control unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "simt_divergence_stack_control_macros.svh"

module simtds_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_i,
  input logic                                 out_valid_i,
  input logic                                 out_ready_i,
  input logic [simtds_pkg::STATUS_W-1:0]      status_i,
  input logic [simtds_pkg::OUT_MASK_W-1:0]    lane_mask_i,
  input logic [simtds_pkg::LEVEL_W-1:0]       stack_level_i
);

  `SIMTDS_ASSERT_NEXT(a_one_item_at_a_time, in_valid_i && in_ready_i, !in_ready_i)
  `SIMTDS_ASSERT_SAME(a_sync_empty_level, out_valid_i && status_i == simtds_pkg::ST_SYNC_EMPTY, stack_level_i == '0)
  `SIMTDS_ASSERT_SAME(a_overflow_level, out_valid_i && status_i == simtds_pkg::ST_OVERFLOW, stack_level_i == simtds_pkg::FULL_LEVEL)
  `SIMTDS_ASSERT_SAME(a_barrier_full_mask, out_valid_i && status_i == simtds_pkg::ST_BARRIER, lane_mask_i == simtds_pkg::OUT_MASK_W'(simtds_pkg::ALL_LANES))
  `SIMTDS_ASSERT_NEXT(a_result_holds, out_valid_i && !out_ready_i, out_valid_i && $stable(status_i))

endmodule

bind simt_divergence_stack_control simtds_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .status_i      (out_o.status),
  .lane_mask_i   (out_o.lane_mask),
  .stack_level_i (out_o.stack_level)
);

/* test/simt_divergence_stack_control_tb.sv */
// ----------------------------------------------------------------------------
// SIMT divergence stack control testbench
// Drives instruction items into the warp control unit and checks every result
// against a cycle-free model of the warp PC, lane mask and divergence stack.
// A directed opening covers the edge cases, then random phases run nested
// if/else regions, deep stack runs and noise between launch register writes.
// Both handshakes idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module simt_divergence_stack_control_tb;
  import simtds_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_COUNT    = 10;
  localparam int PHASE_ITEMS    = 193;

  localparam logic [ACTION_W-1:0] ACT_UNKNOWN_FIRST = ACT_BARRIER + 1'b1;
  localparam logic [ACTION_W-1:0] ACT_UNKNOWN_LAST  = '1;

  typedef struct packed {
    logic [ACTION_W-1:0]        action;
    logic [OFFSET_W-1:0]        offset;
    logic [PRED_W-1:0]          preds;
  } warp_instr_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [OUT_PC_W-1:0]   next_pc;
    logic [OUT_MASK_W-1:0] lane_mask;
    logic [LEVEL_W-1:0]    stack_level;
  } warp_result_t;

  logic clk = 1'b0;
  logic rst_n;

  simtds_cfg_if cfg_if ();
  simtds_in_if  in_if ();
  simtds_out_if out_if ();

  simt_divergence_stack_control uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk = ~clk;

  logic [START_PC_W-1:0] start_pc_reg;
  logic [LANE_COUNT-1:0] launch_mask_reg;
  logic [PC_BITS-1:0]    warp_pc;
  logic [LANE_COUNT-1:0] warp_lanes;
  logic [PC_BITS-1:0]    warp_rejoin;
  simtds_entry_t         warp_stack [STACK_DEPTH];
  int                    warp_depth;

  warp_instr_t  instr_queue [$];
  warp_result_t result_queue [$];
  warp_instr_t  next_instr;
  warp_result_t want;

  int errors = 0;
  int issued = 0;
  int send_hold = 0;
  int send_steady = 0;
  int recv_hold = 0;
  int recv_steady = 0;
  int idle_cycles = 0;

  task automatic launch_warp();
    warp_pc     = PC_BITS'(start_pc_reg);
    warp_lanes  = launch_mask_reg;
    warp_rejoin = '0;
    warp_depth  = 0;
  endtask

  function automatic warp_result_t issue_instruction(input logic [ACTION_W-1:0] act,
                                                     input logic [OFFSET_W-1:0] off,
                                                     input logic [PRED_W-1:0] preds);
    warp_result_t res;
    logic [PC_BITS-1:0] seq_pc;
    logic [PC_BITS-1:0] dest_pc;
    logic [LANE_COUNT-1:0] taken;
    simtds_entry_t top;
    seq_pc     = warp_pc + 1'b1;
    dest_pc    = warp_pc + PC_BITS'(off);
    res.status = ST_DONE;
    case (act)
      ACT_BRANCH: begin
        taken = warp_lanes & preds;
        if (taken == '0) begin
          warp_pc = seq_pc;
        end else if (taken == warp_lanes) begin
          warp_pc    = dest_pc;
          res.status = ST_TAKEN;
        end else if (warp_depth >= STACK_DEPTH) begin
          res.status = ST_OVERFLOW;
        end else begin
          warp_stack[warp_depth] = '{mask: warp_lanes & ~taken, target: seq_pc,
                                     rejoin: warp_rejoin};
          warp_depth++;
          warp_lanes = taken;
          warp_pc    = dest_pc;
          res.status = ST_TAKEN;
        end
      end
      ACT_SSY: begin
        if (warp_depth >= STACK_DEPTH) begin
          res.status = ST_OVERFLOW;
        end else begin
          warp_stack[warp_depth] = '{mask: warp_lanes, target: dest_pc, rejoin: warp_rejoin};
          warp_depth++;
          warp_rejoin = dest_pc;
          warp_pc     = seq_pc;
        end
      end
      ACT_SYNC: begin
        if (warp_depth == 0) begin
          res.status = ST_SYNC_EMPTY;
        end else begin
          top = warp_stack[warp_depth - 1];
          warp_depth--;
          warp_lanes  = top.mask;
          warp_rejoin = top.rejoin;
          warp_pc     = (top.target == warp_pc) ? seq_pc : top.target;
        end
      end
      ACT_BARRIER: begin
        if (warp_lanes != ALL_LANES) begin
          res.status = ST_DIVERGENT;
        end else begin
          res.status = ST_BARRIER;
          warp_pc    = seq_pc;
        end
      end
      default: begin
        warp_pc = seq_pc;
      end
    endcase
    res.next_pc     = OUT_PC_W'(warp_pc);
    res.lane_mask   = OUT_MASK_W'(warp_lanes);
    res.stack_level = LEVEL_W'(warp_depth);
    return res;
  endfunction

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sender side: prediction on every accepted item; a register write relaunches the model.
  always @(posedge clk) begin
    if (!rst_n) begin
      start_pc_reg    = '0;
      launch_mask_reg = ALL_LANES;
      launch_warp();
      in_if.valid <= 1'b0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == CFG_START_PC) begin
          start_pc_reg = cfg_if.data[START_PC_W-1:0];
        end else begin
          launch_mask_reg = cfg_if.data[LANE_COUNT-1:0];
        end
        launch_warp();
      end
      if (in_if.valid && in_if.ready) begin
        result_queue.insert(result_queue.size(),
                            issue_instruction(in_if.action, in_if.branch_offset,
                                              in_if.lane_predicates));
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_hold > 0) begin
          send_hold--;
          in_if.valid <= 1'b0;
        end else if (instr_queue.size() > 0) begin
          next_instr = instr_queue.pop_front();
          in_if.action          <= next_instr.action;
          in_if.branch_offset   <= next_instr.offset;
          in_if.lane_predicates <= next_instr.preds;
          in_if.valid           <= 1'b1;
          if (send_steady > 0) begin
            send_steady--;
          end else if ($urandom_range(0, 49) == 0) begin
            send_steady = $urandom_range(20, 60);
          end else begin
            send_hold = pick_pause();
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver side: compares each result item with the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (result_queue.size() == 0) begin
          $error("result item with no instruction pending: status %0d pc %0h",
                 out_if.status, out_if.next_pc);
          errors++;
        end else begin
          want = result_queue.pop_front();
          if (out_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_if.status);
            errors++;
          end
          if (out_if.next_pc !== want.next_pc) begin
            $error("next_pc: expected %0h, got %0h", want.next_pc, out_if.next_pc);
            errors++;
          end
          if (out_if.lane_mask !== want.lane_mask) begin
            $error("lane_mask: expected %0h, got %0h", want.lane_mask, out_if.lane_mask);
            errors++;
          end
          if (out_if.stack_level !== want.stack_level) begin
            $error("stack_level: expected %0d, got %0d", want.stack_level,
                   out_if.stack_level);
            errors++;
          end
        end
      end
      if (recv_hold > 0) begin
        recv_hold--;
      end else if (recv_steady > 0) begin
        recv_steady--;
      end else if ($urandom_range(0, 49) == 0) begin
        recv_steady = $urandom_range(20, 60);
      end else if ($urandom_range(0, 2) == 0) begin
        recv_hold = pick_pause();
      end
      out_if.ready <= (recv_hold == 0);
    end
  end

  always @(posedge clk) begin
    if ((cfg_if.valid && cfg_if.ready) || (in_if.valid && in_if.ready) ||
        (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic queue_instr(input logic [ACTION_W-1:0] act, input logic [OFFSET_W-1:0] off,
                             input logic [PRED_W-1:0] preds);
    warp_instr_t it;
    it.action = act;
    it.offset = off;
    it.preds  = preds;
    instr_queue.insert(instr_queue.size(), it);
    issued++;
  endtask

  function automatic logic [PRED_W-1:0] pick_preds();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return PRED_W'(1) << $urandom_range(0, PRED_W - 1);
      3: return ~(PRED_W'(1) << $urandom_range(0, PRED_W - 1));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [OFFSET_W-1:0] pick_offset();
    case ($urandom_range(0, 4))
      0: return {1'b1, {(OFFSET_W - 1){1'b0}}};
      1: return {1'b0, {(OFFSET_W - 1){1'b1}}};
      2: return OFFSET_W'($urandom_range(0, 32)) - OFFSET_W'(16);
      default: return OFFSET_W'($urandom());
    endcase
  endfunction

  function automatic logic [ACTION_W-1:0] pick_plain();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return ACT_OTHER;
    if (r < 15) return ACT_BARRIER;
    if (r < 18) return ACT_BRANCH;
    return ACTION_W'($urandom_range(ACT_UNKNOWN_FIRST, ACT_UNKNOWN_LAST));
  endfunction

  // An if/else region: token push, split, body, pop, second body, pop; else plain items.
  task automatic emit_region(input int nest);
    int n;
    if (nest > 0 && $urandom_range(0, 2) != 0) begin
      queue_instr(ACT_SSY, pick_offset(), $urandom());
      queue_instr(ACT_BRANCH, pick_offset(), pick_preds());
      emit_region(nest - 1);
      queue_instr(ACT_SYNC, pick_offset(), $urandom());
      emit_region(nest - 1);
      queue_instr(ACT_SYNC, pick_offset(), $urandom());
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) queue_instr(pick_plain(), pick_offset(), pick_preds());
    end
  endtask

  task automatic emit_deep_run();
    int n;
    n = $urandom_range(12, 20);
    repeat (n) begin
      if ($urandom_range(0, 1) == 0) begin
        queue_instr(ACT_SSY, pick_offset(), $urandom());
      end else begin
        queue_instr(ACT_BRANCH, pick_offset(), $urandom());
      end
    end
    repeat (n + $urandom_range(0, 2)) queue_instr(ACT_SYNC, pick_offset(), $urandom());
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (instr_queue.size() != 0 || in_if.valid || result_queue.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_launch_mask(input int phase);
    if (phase % 2 == 0) return ALL_LANES;
    case ($urandom_range(0, 4))
      0: return {1'b0, {(LANE_COUNT - 1){1'b1}}};
      1: return {{(LANE_COUNT - 1){1'b1}}, 1'b0};
      2: return CFG_DATA_W'(1) << $urandom_range(0, LANE_COUNT - 1);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_start_pc();
    logic [START_PC_W-1:0] pc;
    case ($urandom_range(0, 2))
      0: pc = '0;
      1: pc = '1;
      default: pc = START_PC_W'($urandom());
    endcase
    return {(CFG_DATA_W - START_PC_W)'($urandom_range(0, 65535)), pc};
  endfunction

  initial begin
    int phase_start;
    int r;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = CFG_START_PC;
    cfg_if.data           = '0;
    in_if.valid           = 1'b0;
    in_if.action          = ACT_OTHER;
    in_if.branch_offset   = '0;
    in_if.lane_predicates = '0;
    out_if.ready          = 1'b0;
    rst_n                 = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    queue_instr(ACT_OTHER, {1'b0, {(OFFSET_W - 1){1'b1}}}, '0);
    for (int a = ACT_UNKNOWN_FIRST; a <= ACT_UNKNOWN_LAST; a++) begin
      queue_instr(ACTION_W'(a), '1, '1);
    end
    queue_instr(ACT_BARRIER, '0, '0);
    queue_instr(ACT_BRANCH, OFFSET_W'(9), '0);
    queue_instr(ACT_BRANCH, {1'b1, {(OFFSET_W - 1){1'b0}}}, '1);
    queue_instr(ACT_SSY, {1'b0, {(OFFSET_W - 1){1'b1}}}, '0);
    queue_instr(ACT_BRANCH, OFFSET_W'(3), 32'h0000_FFFF);
    queue_instr(ACT_BARRIER, '0, '1);
    queue_instr(ACT_SYNC, '0, '0);
    queue_instr(ACT_SYNC, '0, '0);
    queue_instr(ACT_SYNC, '0, '0);
    // A token whose target is the sync itself falls through to the next PC.
    queue_instr(ACT_SSY, OFFSET_W'(1), '0);
    queue_instr(ACT_SYNC, '0, '0);
    wait_idle();

    write_register(CFG_START_PC, 32'hABCD_FFFF);
    write_register(CFG_LAUNCH_MASK, '0);
    queue_instr(ACT_OTHER, '0, '0);
    queue_instr(ACT_BRANCH, OFFSET_W'(7), '1);
    queue_instr(ACT_BARRIER, '0, '1);
    queue_instr(ACT_SSY, '1, '0);
    queue_instr(ACT_SYNC, '0, '0);

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_idle();
      r = $urandom_range(0, 2);
      if (r != 1) write_register(CFG_START_PC, pick_start_pc());
      if (r != 0) write_register(CFG_LAUNCH_MASK, pick_launch_mask(phase));
      phase_start = issued;
      while (issued - phase_start < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          emit_region($urandom_range(1, 3));
        end else if (r < 80) begin
          emit_deep_run();
        end else begin
          repeat ($urandom_range(1, 6)) begin
            queue_instr(ACTION_W'($urandom_range(0, 7)), OFFSET_W'($urandom()), $urandom());
          end
        end
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/simtds_pkg.sv
hw/rtl/simtds_if.sv
hw/rtl/simtds_ctrl.sv
hw/rtl/simtds_datapath.sv
hw/rtl/simt_divergence_stack_control.sv
hw/rtl/simtds_checker.sv
test/simt_divergence_stack_control_tb.sv
